>>> hdl/pla_pkg.sv
// ============================================================================
// pla_pkg: shared types and constants for path loss attenuation
// Result and side-band structs, register codes, fixed-point constants and the
// Q0.32 table of 2^-(2^-i) used by the exponent pipeline.
// ============================================================================
package pla_pkg;

    localparam int PLA_LOG_TABLE_BITS = 8;
    localparam int PLA_EXP_STEPS      = 16;

    // log10(2) in Q0.16, log2(10)/10 in Q0.16, three decades (m to km) in Q.16
    localparam int PLA_LOG10_2_Q16    = 19728;
    localparam int PLA_LOG2_10_Q16    = 21771;
    localparam int PLA_KM_DECADES_Q16 = 196608;

    // configuration register indexes
    localparam logic [2:0] PLA_REG_MODEL    = 3'd0;
    localparam logic [2:0] PLA_REG_ALPHA    = 3'd1;
    localparam logic [2:0] PLA_REG_BETA     = 3'd2;
    localparam logic [2:0] PLA_REG_GAIN     = 3'd3;
    localparam logic [2:0] PLA_REG_ADDITIVE = 3'd4;

    typedef struct packed {
        logic signed [15:0] loss_db;
        logic [7:0]         shift;
        logic               clip;
    } t_pla_side;

    typedef struct packed {
        logic signed [15:0] loss_db;
        logic [15:0]        mantissa;
        logic [7:0]         shift;
        logic               clip;
    } t_pla_result;

    typedef logic [PLA_EXP_STEPS-1:0][31:0] t_exp_tbl;

    function automatic logic [63:0] pla_isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // entry i holds 2^-(2^-(i+1)) in Q0.32, built by repeated square roots
    function automatic t_exp_tbl pla_exp_table();
        t_exp_tbl    tbl;
        logic [63:0] c;
        c = 64'h0000_0000_8000_0000;
        for (int i = 0; i < PLA_EXP_STEPS; i++) begin
            c = pla_isqrt64(c << 32);
            if (c > 64'h0000_0000_FFFF_FFFF) begin
                c = 64'h0000_0000_FFFF_FFFF;
            end
            tbl[i] = c[31:0];
        end
        return tbl;
    endfunction

    localparam t_exp_tbl PLA_EXP_C = pla_exp_table();

endpackage

>>> hdl/pla_log2.sv
// ============================================================================
// pla_log2: pipelined base-2 logarithm of a 32-bit distance
// Stage 0 finds the leading one and normalizes to Q1.31; each following
// stage squares the mantissa once and yields one fraction bit.
// ============================================================================
module pla_log2 #(
    parameter int LOG_TABLE_BITS = pla_pkg::PLA_LOG_TABLE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [31:0]               i_distance,
    output logic                      o_valid,
    output logic                      o_zero,
    output logic [LOG_TABLE_BITS+4:0] o_log2
);
    import pla_pkg::*;

    localparam int B = LOG_TABLE_BITS;

    logic [B:0]   r_valid;
    logic [B:0]   r_zero;
    logic [4:0]   r_p [0:B];
    logic [31:0]  r_m [0:B-1];
    logic [B-1:0] r_f [1:B];

    logic [4:0]   n_p0;
    logic [31:0]  n_m0;
    logic [63:0]  sq [0:B-1];

    always_comb begin
        n_p0 = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_distance[i]) begin
                n_p0 = 5'(i);
            end
        end
        n_m0 = i_distance << (5'd31 - n_p0);
    end

    // one square per stage; bit 63 set means the square reached two
    always_comb begin
        for (int k = 0; k < B; k++) begin
            sq[k] = 64'(r_m[k]) * 64'(r_m[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[B-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= {r_zero[B-1:0], (i_distance == 32'd0)};
        r_p[0] <= n_p0;
        r_m[0] <= n_m0;
        r_f[1] <= {{(B-1){1'b0}}, sq[0][63]};
        for (int k = 0; k < B; k++) begin
            r_p[k+1] <= r_p[k];
        end
        for (int k = 0; k < B - 1; k++) begin
            r_m[k+1] <= sq[k][63] ? sq[k][63:32] : sq[k][62:31];
        end
        for (int k = 1; k < B; k++) begin
            r_f[k+1] <= {r_f[k][B-2:0], sq[k][63]};
        end
    end

    assign o_valid = r_valid[B];
    assign o_zero  = r_zero[B];
    assign o_log2  = {r_p[B], r_f[B]};

endmodule

>>> hdl/pla_exp2.sv
// ============================================================================
// pla_exp2: pipelined 2^-r for a Q0.16 fraction r
// One stage per fraction bit: a set bit multiplies the Q0.32 accumulator by
// its table constant and keeps the upper 32 bits.
// ============================================================================
module pla_exp2 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [15:0]        i_frac,
    input  pla_pkg::t_pla_side i_side,
    output logic               o_valid,
    output logic [31:0]        o_acc,
    output pla_pkg::t_pla_side o_side
);
    import pla_pkg::*;

    localparam int Steps = PLA_EXP_STEPS;

    logic [Steps-1:0] r_valid;
    logic [31:0]      r_acc  [0:Steps-1];
    logic [15:0]      r_frac [0:Steps-1];
    t_pla_side        r_side [0:Steps-1];

    logic [31:0]      src_acc  [0:Steps-1];
    logic [15:0]      src_frac [0:Steps-1];
    t_pla_side        src_side [0:Steps-1];
    logic [63:0]      prod     [0:Steps-1];
    logic [31:0]      n_acc    [0:Steps-1];

    always_comb begin
        for (int k = 0; k < Steps; k++) begin
            if (k == 0) begin
                src_acc[k]  = 32'hFFFF_FFFF;
                src_frac[k] = i_frac;
                src_side[k] = i_side;
            end else begin
                src_acc[k]  = r_acc[k-1];
                src_frac[k] = r_frac[k-1];
                src_side[k] = r_side[k-1];
            end
            prod[k]  = 64'(src_acc[k]) * 64'(PLA_EXP_C[k]);
            n_acc[k] = src_frac[k][Steps-1-k] ? prod[k][63:32] : src_acc[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[Steps-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Steps; k++) begin
            r_acc[k]  <= n_acc[k];
            r_frac[k] <= src_frac[k];
            r_side[k] <= src_side[k];
        end
    end

    assign o_valid = r_valid[Steps-1];
    assign o_acc   = r_acc[Steps-1];
    assign o_side  = r_side[Steps-1];

endmodule

>>> hdl/path_loss_attenuation.sv
// ============================================================================
// path_loss_attenuation: log-distance path loss with linear attenuation
// Distance in, loss in dB (Q8.8) and attenuation as mantissa and shift out.
//
//   channel  direction  handshake         payload
//   input    in         i_valid/o_stall   i_link_distance
//   result   out        o_valid/i_stall   o_loss_db, o_atten_mantissa,
//                                         o_atten_shift, o_gain_clipped
//   config   in         i_cfg_wr_en       i_cfg_index, i_cfg_wdata
//
// One distance per cycle while o_stall is low; once its beat is taken, a result
// passes the squaring stages of the logarithm and the sixteen multiply stages
// of the exponent. The pipeline never halts: results land in an output FIFO,
// and o_stall rises once the beats in flight fill it.
// Reset is synchronous and clears only control state and the registers.
// ============================================================================
module path_loss_attenuation #(
    parameter int LOG_TABLE_BITS = pla_pkg::PLA_LOG_TABLE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_link_distance,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_loss_db,
    output logic [15:0]        o_atten_mantissa,
    output logic [7:0]         o_atten_shift,
    output logic               o_gain_clipped,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata
);
    import pla_pkg::*;

    localparam int B         = LOG_TABLE_BITS;
    localparam int FifoDepth = 1 << $clog2(B + 28);
    localparam int AddrW     = $clog2(FifoDepth);

    localparam logic signed [B+6:0]  LogBias  = (B+7)'(8 << B);
    localparam logic signed [16:0]   Log10Of2 = 17'(PLA_LOG10_2_Q16);
    localparam logic signed [20:0]   KmShift  = 21'(PLA_KM_DECADES_Q16);
    localparam logic signed [36:0]   Round    = 37'(32768);
    localparam logic [14:0]          Log2Of10 = 15'(PLA_LOG2_10_Q16);

    // configuration
    logic               r_model;
    logic signed [15:0] r_alpha;
    logic signed [15:0] r_beta;
    logic signed [15:0] r_gain;
    logic signed [15:0] r_additive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model    <= 1'b0;
            r_alpha    <= '0;
            r_beta     <= '0;
            r_gain     <= '0;
            r_additive <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                PLA_REG_MODEL:    r_model    <= i_cfg_wdata[0];
                PLA_REG_ALPHA:    r_alpha    <= i_cfg_wdata;
                PLA_REG_BETA:     r_beta     <= i_cfg_wdata;
                PLA_REG_GAIN:     r_gain     <= i_cfg_wdata;
                PLA_REG_ADDITIVE: r_additive <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input beat and credit count
    logic                 in_accept;
    logic                 out_deliver;
    logic [AddrW:0]       r_used;

    assign in_accept   = i_valid && !o_stall;
    assign out_deliver = o_valid && !i_stall;
    assign o_stall     = (r_used >= (AddrW+1)'(FifoDepth));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= r_used + (AddrW+1)'(in_accept) - (AddrW+1)'(out_deliver);
        end
    end

    // logarithm
    logic           lg_valid;
    logic           lg_zero;
    logic [B+4:0]   lg_log2;

    pla_log2 #(
        .LOG_TABLE_BITS(B)
    ) u_log2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_accept),
        .i_distance (i_link_distance),
        .o_valid    (lg_valid),
        .o_zero     (lg_zero),
        .o_log2     (lg_log2)
    );

    // stage L1: log10 in Q.16, minus three decades in macrocell mode
    logic signed [B+6:0]  l2;
    logic signed [B+23:0] lgm;
    logic signed [20:0]   n_lg;
    logic                 r_l1_valid;
    logic                 r_l1_zero;
    logic signed [20:0]   r_lg;

    always_comb begin
        l2   = signed'({2'b00, lg_log2}) - LogBias;
        lgm  = (B+24)'(l2) * (B+24)'(Log10Of2);
        n_lg = 21'(lgm >>> B);
        if (r_model) begin
            n_lg = n_lg - KmShift;
        end
    end

    // stage L2: scale by the slope
    logic signed [15:0]   coef;
    logic                 r_l2_valid;
    logic                 r_l2_zero;
    logic signed [36:0]   r_prod;

    assign coef = r_model ? r_gain : r_alpha;

    // stage L3: round, add offset, saturate
    logic signed [20:0]   term;
    logic signed [21:0]   sum;
    logic signed [15:0]   n_loss;
    logic signed [15:0]   offset;
    logic                 r_l3_valid;
    logic signed [15:0]   r_loss;

    assign offset = r_model ? r_additive : r_beta;

    always_comb begin
        term = 21'((r_prod + Round) >>> 16);
        sum  = 22'(offset);
        if (!r_l2_zero) begin
            sum = sum + 22'(term);
        end
        if (sum > 22'sd32767) begin
            n_loss = 16'sh7FFF;
        end else if (sum < -22'sd32768) begin
            n_loss = 16'sh8000;
        end else begin
            n_loss = 16'(sum);
        end
    end

    // stage L4: loss in dB to a power of two, split integer and fraction
    logic [29:0]          e;
    logic                 r_l4_valid;
    logic [15:0]          r_frac;
    t_pla_side            r_side;

    assign e = 30'(r_loss[14:0]) * 30'(Log2Of10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_valid <= 1'b0;
            r_l2_valid <= 1'b0;
            r_l3_valid <= 1'b0;
            r_l4_valid <= 1'b0;
        end else begin
            r_l1_valid <= lg_valid;
            r_l2_valid <= r_l1_valid;
            r_l3_valid <= r_l2_valid;
            r_l4_valid <= r_l3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1_zero      <= lg_zero;
        r_lg           <= n_lg;
        r_l2_zero      <= r_l1_zero;
        r_prod         <= 37'(coef) * 37'(r_lg);
        r_loss         <= n_loss;
        r_frac         <= e[23:8];
        r_side.loss_db <= r_loss;
        r_side.shift   <= 8'(e[29:24]);
        r_side.clip    <= r_loss[15];
    end

    // exponent
    logic        ex_valid;
    logic [31:0] ex_acc;
    t_pla_side   ex_side;

    pla_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_l4_valid),
        .i_frac  (r_frac),
        .i_side  (r_side),
        .o_valid (ex_valid),
        .o_acc   (ex_acc),
        .o_side  (ex_side)
    );

    t_pla_result res;

    always_comb begin
        res.loss_db = ex_side.loss_db;
        res.clip    = ex_side.clip;
        if (ex_side.clip) begin
            res.mantissa = 16'hFFFF;
            res.shift    = '0;
        end else begin
            res.mantissa = ex_acc[31] ? ex_acc[31:16] : 16'h8000;
            res.shift    = ex_side.shift;
        end
    end

    // output FIFO and result register
    t_pla_result       mem [0:FifoDepth-1];
    logic [AddrW-1:0]  r_wptr;
    logic [AddrW-1:0]  r_rptr;
    logic [AddrW:0]    r_count;
    logic              load;
    logic              r_out_valid;
    t_pla_result       r_out;

    assign load = (r_count != '0) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (ex_valid) begin
            mem[r_wptr] <= res;
        end
        if (load) begin
            r_out <= mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ex_valid) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (load) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (AddrW+1)'(ex_valid) - (AddrW+1)'(load);
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_deliver) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_loss_db        = r_out.loss_db;
    assign o_atten_mantissa = r_out.mantissa;
    assign o_atten_shift    = r_out.shift;
    assign o_gain_clipped   = r_out.clip;

endmodule

>>> dv/tb_top.sv
// ============================================================================
// tb_top: testbench for path_loss_attenuation
// Walks a directed table of distances and register settings, then streams
// random distances under changing coefficient sets. Every result beat is
// checked field by field against its table entry or a bit-exact predictor of
// the log-distance loss and its mantissa/shift attenuation. Both channels idle at random.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pla_pkg::*;

    localparam int PIPE_DEPTH   = PLA_LOG_TABLE_BITS + 23;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 150;

    localparam t_pla_result RES_NONE  = '0;
    localparam t_pla_result RES_ONE   = '{16'sd0, 16'hFFFF, 8'd0, 1'b0};
    localparam t_pla_result RES_FLOOR = '{-16'sd32768, 16'hFFFF, 8'd0, 1'b1};

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    typedef struct packed {
        logic        load;
        logic [15:0] mode_word;
        logic [15:0] alpha;
        logic [15:0] beta;
        logic [15:0] gain;
        logic [15:0] additive;
        logic [31:0] distance;
        logic        typed;
        t_pla_result want;
    } t_dir_row;

    localparam int DIR_ROWS = 23;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // registers at reset: every loss is zero
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, RES_ONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1, RES_ONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0100, 1'b1, RES_ONE},
        // typical alpha/beta link: 20 dB/decade, 40 dB at one metre
        '{1'b1, 16'h0000, 16'h1400, 16'h2800, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0100, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0003_E800, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0001, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000, 1'b0, RES_NONE},
        // upper mode bits ignored: still alpha/beta, most negative offset
        '{1'b1, 16'hFFFE, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 32'h0000_0000, 1'b1, RES_FLOOR},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1, RES_FLOOR},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_3039, 1'b1, RES_FLOOR},
        // macrocell with extreme gain and additive: saturate both ways
        '{1'b1, 16'h0001, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0001, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0003_E800, 1'b0, RES_NONE},
        // macrocell with zero terms: alpha/beta must not leak in
        '{1'b1, 16'h0003, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 32'h1234_5678, 1'b1, RES_ONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, RES_ONE},
        // macrocell gain against a large negative additive, then extreme alpha/beta
        '{1'b1, 16'h0001, 16'h0000, 16'h0000, 16'h2300, 16'h8000, 32'h0027_1000, 1'b0, RES_NONE},
        '{1'b1, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, RES_NONE},
        '{1'b1, 16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 32'h0000_0001, 1'b0, RES_NONE},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_00FF, 1'b0, RES_NONE}
    };

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic               o_stall;
    logic [31:0]        i_link_distance  = '0;
    logic               o_valid;
    logic               i_stall          = 1'b0;
    logic signed [15:0] o_loss_db;
    logic [15:0]        o_atten_mantissa;
    logic [7:0]         o_atten_shift;
    logic               o_gain_clipped;
    logic               i_cfg_wr_en      = 1'b0;
    logic [2:0]         i_cfg_index      = '0;
    logic [15:0]        i_cfg_wdata      = '0;

    // shadow of the block's registers
    logic               sh_macro    = 1'b0;
    logic signed [15:0] sh_alpha    = '0;
    logic signed [15:0] sh_beta     = '0;
    logic signed [15:0] sh_gain     = '0;
    logic signed [15:0] sh_additive = '0;

    t_pla_result  loss_due[$];
    int           mismatches  = 0;
    int           cycle_count = 0;
    t_stall_style stall_style = STALL_NONE;
    int           stall_hold  = 0;
    logic [2:0]   stall_tick  = '0;

    path_loss_attenuation u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_link_distance  (i_link_distance),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_loss_db        (o_loss_db),
        .o_atten_mantissa (o_atten_mantissa),
        .o_atten_shift    (o_atten_shift),
        .o_gain_clipped   (o_gain_clipped),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] trial;
        int          b;
        res = '0;
        for (b = 31; b >= 0; b--) begin
            trial = res | (64'd1 << b);
            if (trial * trial <= v) begin
                res = trial;
            end
        end
        return res;
    endfunction

    function automatic t_pla_result path_loss_of(input logic [31:0] d);
        t_pla_result r;
        longint      loss;
        longint      coef;
        longint      l2;
        longint      lg;
        longint      frac;
        longint      e;
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] c;
        logic [15:0] rbits;
        int          p;
        int          i;
        coef = sh_macro ? longint'(sh_gain) : longint'(sh_alpha);
        loss = sh_macro ? longint'(sh_additive) : longint'(sh_beta);
        if (d != 32'd0) begin
            p = 31;
            while (d[p] == 1'b0) begin
                p--;
            end
            // normalize to Q1.31 and pull fraction bits out by squaring
            m = 64'(d) << (31 - p);
            frac = 0;
            for (i = 0; i < PLA_LOG_TABLE_BITS; i++) begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000) begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            l2 = longint'(p) * (1 << PLA_LOG_TABLE_BITS) + frac
                 - 8 * (1 << PLA_LOG_TABLE_BITS);
            lg = (l2 * PLA_LOG10_2_Q16) >>> PLA_LOG_TABLE_BITS;
            if (sh_macro) begin
                lg = lg - PLA_KM_DECADES_Q16;
            end
            loss = loss + ((coef * lg + 32768) >>> 16);
        end
        if (loss > 32767) begin
            loss = 32767;
        end
        if (loss < -32768) begin
            loss = -32768;
        end
        r.loss_db = loss[15:0];
        if (loss < 0) begin
            r.mantissa = 16'hFFFF;
            r.shift    = 8'd0;
            r.clip     = 1'b1;
        end else begin
            e     = (loss * PLA_LOG2_10_Q16) >>> 8;
            rbits = e[15:0];
            acc   = 64'h0000_0000_FFFF_FFFF;
            c     = 64'h0000_0000_8000_0000;
            for (i = 1; i <= PLA_EXP_STEPS; i++) begin
                c = floor_root(c << 32);
                if (rbits[PLA_EXP_STEPS - i]) begin
                    acc = (acc * c) >> 32;
                end
            end
            acc = acc >> 16;
            if (acc < 64'd32768) begin
                acc = 64'd32768;
            end
            if (acc > 64'd65535) begin
                acc = 64'd65535;
            end
            r.mantissa = acc[15:0];
            r.shift    = ((e >> 16) > 255) ? 8'd255 : 8'(e >> 16);
            r.clip     = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [15:0] draw_coef(input int span);
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2:       v = 16'($urandom);
            default: v = 16'(int'($urandom_range(0, 2 * span)) - span);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] draw_distance();
        logic [31:0] d;
        case ($urandom_range(0, 9))
            0:          d = '0;
            1:          d = $urandom;
            2, 3, 4, 5: d = $urandom >> $urandom_range(0, 31);
            6:          d = 32'h0003_E800 + $urandom_range(0, 4096) - 32'd2048;
            7:          d = 32'd1 << $urandom_range(0, 31);
            8:          d = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default:    d = (32'd1 << $urandom_range(1, 31)) - 32'd1;
        endcase
        return d;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            PLA_REG_MODEL:    sh_macro    = data[0];
            PLA_REG_ALPHA:    sh_alpha    = data;
            PLA_REG_BETA:     sh_beta     = data;
            PLA_REG_GAIN:     sh_gain     = data;
            PLA_REG_ADDITIVE: sh_additive = data;
            default:          ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] mode_word, input logic [15:0] alpha,
                                input logic [15:0] beta, input logic [15:0] gain,
                                input logic [15:0] additive);
        int idx;
        write_reg(PLA_REG_MODEL, mode_word);
        write_reg(PLA_REG_ALPHA, alpha);
        write_reg(PLA_REG_BETA, beta);
        write_reg(PLA_REG_GAIN, gain);
        write_reg(PLA_REG_ADDITIVE, additive);
        // unused indexes must leave every register alone
        for (idx = int'(PLA_REG_ADDITIVE) + 1; idx < 8; idx++) begin
            write_reg(3'(idx), 16'($urandom));
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_all_landed();
        i_valid <= 1'b0;
        while (loss_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_gap(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_beat(input logic [31:0] d, input logic typed, input t_pla_result want);
        i_valid         <= 1'b1;
        i_link_distance <= d;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        loss_due.push_back(typed ? want : path_loss_of(d));
    endtask

    task automatic report_field(input string what, input logic signed [63:0] want_v,
                                input logic signed [63:0] got_v);
        mismatches++;
        $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
    endtask

    // receiver stall pattern, restyled whenever its random hold count runs out
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 3'd1;
        if (stall_hold == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            stall_hold  <= $urandom_range(20, 300);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_style)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: i_stall <= (stall_tick < 3'd3);
            default:        i_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        t_pla_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (loss_due.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with no prediction waiting", $time);
            end else begin
                want = loss_due.pop_front();
                if (o_loss_db !== want.loss_db) begin
                    report_field("loss_db", want.loss_db, o_loss_db);
                end
                if (o_atten_mantissa !== want.mantissa) begin
                    report_field("atten_mantissa", want.mantissa, o_atten_mantissa);
                end
                if (o_atten_shift !== want.shift) begin
                    report_field("atten_shift", want.shift, o_atten_shift);
                end
                if (o_gain_clipped !== want.clip) begin
                    report_field("gain_clipped", want.clip, o_gain_clipped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int r;
        int phase;
        int k;
        int burst_left;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].load) begin
                wait_all_landed();
                program_regs(DIR_TABLE[r].mode_word, DIR_TABLE[r].alpha, DIR_TABLE[r].beta,
                             DIR_TABLE[r].gain, DIR_TABLE[r].additive);
            end
            send_beat(DIR_TABLE[r].distance, DIR_TABLE[r].typed, DIR_TABLE[r].want);
            if ($urandom_range(0, 3) == 0) begin
                idle_gap($urandom_range(1, 6));
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_all_landed();
            program_regs(16'($urandom), draw_coef(40 * 256), draw_coef(120 * 256),
                         draw_coef(40 * 256), draw_coef(120 * 256));
            burst_left = 0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (burst_left == 0) begin
                    if (k != 0) begin
                        idle_gap($urandom_range(1, 15));
                    end
                    // long bursts now and then keep the output FIFO under pressure
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                end
                send_beat(draw_distance(), 1'b0, RES_NONE);
                burst_left--;
            end
        end

        wait_all_landed();
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0 && loss_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
